@@ rtl/core/tfb_pkg.sv @@
// Shared types, codes and constants of the tangent frame builder.
package tfb_pkg;

  localparam int PEAK_W = 31;
  localparam int ACC_W = 67;

  // configuration register indexes
  localparam logic REG_TOL = 1'b0;
  localparam logic REG_SWITCH = 1'b1;

  localparam logic [PEAK_W-1:0] TOL_RESET = 31'd11;
  localparam logic [PEAK_W-1:0] SWITCH_RESET = 31'd966367642;

  // status codes
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_UNIT = 2'd1;
  localparam logic [1:0] ST_DEGEN = 2'd2;

  // multiplier operand codes: w = working vector, m = unit vector, e = first tangent
  localparam logic [3:0] OP_WX = 4'd0;
  localparam logic [3:0] OP_WY = 4'd1;
  localparam logic [3:0] OP_WZ = 4'd2;
  localparam logic [3:0] OP_MX = 4'd3;
  localparam logic [3:0] OP_MY = 4'd4;
  localparam logic [3:0] OP_MZ = 4'd5;
  localparam logic [3:0] OP_EX = 4'd6;
  localparam logic [3:0] OP_EY = 4'd7;
  localparam logic [3:0] OP_EZ = 4'd8;

  typedef struct packed {
    logic [3:0] a_sel;
    logic [3:0] b_sel;
    logic       neg;
    logic       first;
    logic       last;
  } mac_op_t;

  localparam int PROG_LEN = 18;

  // program entry and end points
  localparam logic [4:0] PC_SQ = 5'd0;
  localparam logic [4:0] PC_CROSS = 5'd3;
  localparam logic [4:0] PC_DOT = 5'd9;
  localparam logic [4:0] PC_SQ_END = 5'd2;
  localparam logic [4:0] PC_CX_END = 5'd4;
  localparam logic [4:0] PC_CY_END = 5'd6;
  localparam logic [4:0] PC_CZ_END = 5'd8;
  localparam logic [4:0] PC_D0_END = 5'd11;
  localparam logic [4:0] PC_D1_END = 5'd14;
  localparam logic [4:0] PC_D2_END = 5'd17;

  localparam mac_op_t MAC_PROG [PROG_LEN] = '{
    '{OP_WX, OP_WX, 1'b0, 1'b1, 1'b0},
    '{OP_WY, OP_WY, 1'b0, 1'b0, 1'b0},
    '{OP_WZ, OP_WZ, 1'b0, 1'b0, 1'b1},
    '{OP_MY, OP_EZ, 1'b0, 1'b1, 1'b0},
    '{OP_MZ, OP_EY, 1'b1, 1'b0, 1'b1},
    '{OP_MZ, OP_EX, 1'b0, 1'b1, 1'b0},
    '{OP_MX, OP_EZ, 1'b1, 1'b0, 1'b1},
    '{OP_MX, OP_EY, 1'b0, 1'b1, 1'b0},
    '{OP_MY, OP_EX, 1'b1, 1'b0, 1'b1},
    '{OP_MX, OP_EX, 1'b0, 1'b1, 1'b0},
    '{OP_MY, OP_EY, 1'b0, 1'b0, 1'b0},
    '{OP_MZ, OP_EZ, 1'b0, 1'b0, 1'b1},
    '{OP_MX, OP_WX, 1'b0, 1'b1, 1'b0},
    '{OP_MY, OP_WY, 1'b0, 1'b0, 1'b0},
    '{OP_MZ, OP_WZ, 1'b0, 1'b0, 1'b1},
    '{OP_EX, OP_WX, 1'b0, 1'b1, 1'b0},
    '{OP_EY, OP_WY, 1'b0, 1'b0, 1'b0},
    '{OP_EZ, OP_WZ, 1'b0, 1'b0, 1'b1}
  };

  function automatic logic [PEAK_W-1:0] sat31(input logic [ACC_W-1:0] v);
    sat31 = (|v[ACC_W-1:PEAK_W]) ? '1 : v[PEAK_W-1:0];
  endfunction

endpackage

@@ rtl/core/tfb_vec_if.sv @@
// Input vector channel.
interface tfb_vec_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic               last_in_batch;

  modport source(output valid, vec_x, vec_y, vec_z, last_in_batch, input ready);
  modport sink(input valid, vec_x, vec_y, vec_z, last_in_batch, output ready);
endinterface

@@ rtl/core/tfb_frame_if.sv @@
// Result frame channel.
interface tfb_frame_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] unit_x;
  logic signed [31:0] unit_y;
  logic signed [31:0] unit_z;
  logic signed [31:0] first_x;
  logic signed [31:0] first_y;
  logic signed [31:0] first_z;
  logic signed [31:0] second_x;
  logic signed [31:0] second_y;
  logic signed [31:0] second_z;
  logic [1:0]         status;
  logic [30:0]        peak_norm_error;
  logic [30:0]        peak_basis_dot;

  modport source(output valid, unit_x, unit_y, unit_z, first_x, first_y, first_z,
                 second_x, second_y, second_z, status, peak_norm_error, peak_basis_dot,
                 input ready);
  modport sink(input valid, unit_x, unit_y, unit_z, first_x, first_y, first_z,
               second_x, second_y, second_z, status, peak_norm_error, peak_basis_dot,
               output ready);
endinterface

@@ rtl/core/tfb_cfg_if.sv @@
// Configuration write channel.
interface tfb_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [30:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/core/tangent_frame_builder.sv @@
// Top level: sequencer, shared multiplier-accumulator, serial root and divide units.
//
//  channel | modport | transaction
//  --------+---------+-------------------------------------------------
//  vec     | sink    | one vector x, y, z plus batch-end flag
//  frame   | source  | unit vector, two tangents, status, batch peaks
//  cfg     | sink    | register index and 31-bit write data
//
// One vector at a time: 24 multiply-accumulate steps, three square roots and nine
// divisions per vector; a vector that is not unit leaves right after its first square
// root. The serial divider takes most of the time per vector.
// A new vector is taken only after the previous frame transaction completes.
// Reset clears the sequencer, the peaks and loads the register defaults.
module tangent_frame_builder #(
  parameter int FRACTION_BITS = 30
) (
  input logic clk,
  input logic rst,
  tfb_vec_if.sink     vec,
  tfb_frame_if.source frame,
  tfb_cfg_if.sink     cfg
);
  import tfb_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL = 3'd1;
  localparam logic [2:0] S_ACC = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_DIV = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  localparam logic [1:0] PH_IN = 2'd0;
  localparam logic [1:0] PH_E1 = 2'd1;
  localparam logic [1:0] PH_E2 = 2'd2;

  localparam logic [32:0] ONE = 33'd1 << FRACTION_BITS;

  logic [2:0]  state;
  logic [1:0]  phase;
  logic [4:0]  pc;
  logic [1:0]  di;
  logic [1:0]  status;
  logic        last;
  logic [PEAK_W-1:0] tol;
  logic [PEAK_W-1:0] sw;
  logic [PEAK_W-1:0] err_peak;
  logic [PEAK_W-1:0] dot_peak;

  logic signed [32:0] wx, wy, wz, mx, my, mz, ex, ey, ez;
  logic signed [32:0] opa, opb;
  logic signed [65:0] prod;
  logic signed [ACC_W-1:0] acc, acc_sum;
  logic [ACC_W-1:0] mag, scaled;
  logic signed [32:0] res;
  logic [31:0] n;
  mac_op_t op;

  logic        sqrt_start, sqrt_done;
  logic [31:0] root;
  logic [32:0] diff;
  logic [31:0] err;
  logic        div_start, div_done;
  logic [31:0] div_q;
  logic signed [32:0] div_src;
  logic [31:0] div_mag;
  logic signed [32:0] qs;

  function automatic logic signed [32:0] pick(input logic [3:0] code,
      input logic signed [32:0] a0, a1, a2, b0, b1, b2, c0, c1, c2);
    case (code)
      OP_WX:   pick = a0;
      OP_WY:   pick = a1;
      OP_WZ:   pick = a2;
      OP_MX:   pick = b0;
      OP_MY:   pick = b1;
      OP_MZ:   pick = b2;
      OP_EX:   pick = c0;
      OP_EY:   pick = c1;
      OP_EZ:   pick = c2;
      default: pick = '0;
    endcase
  endfunction

  always_comb begin
    op = MAC_PROG[pc];
    opa = pick(op.a_sel, wx, wy, wz, mx, my, mz, ex, ey, ez);
    opb = pick(op.b_sel, wx, wy, wz, mx, my, mz, ex, ey, ez);
    acc_sum = (op.first ? ACC_W'(0) : acc) + (op.neg ? -ACC_W'(prod) : ACC_W'(prod));
    mag = acc_sum[ACC_W-1] ? ACC_W'(-acc_sum) : acc_sum;
    // truncation toward zero works on the magnitude
    scaled = mag >> FRACTION_BITS;
    res = acc_sum[ACC_W-1] ? -scaled[32:0] : scaled[32:0];
    diff = {1'b0, root} - ONE;
    err = diff[32] ? 32'(-diff) : diff[31:0];
    case (di)
      2'd0:    div_src = wx;
      2'd1:    div_src = wy;
      default: div_src = wz;
    endcase
    div_mag = div_src[32] ? 32'(-div_src) : div_src[31:0];
    qs = div_src[32] ? -{1'b0, div_q} : {1'b0, div_q};
  end

  tfb_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .radicand(acc[63:0]),
    .done(sqrt_done), .root(root)
  );

  tfb_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_mag), .divisor(n),
    .done(div_done), .quotient(div_q)
  );

  assign cfg.ready = 1'b1;
  assign vec.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_IN;
      pc <= PC_SQ;
      di <= 2'd0;
      status <= ST_OK;
      last <= 1'b0;
      tol <= TOL_RESET;
      sw <= SWITCH_RESET;
      err_peak <= '0;
      dot_peak <= '0;
      sqrt_start <= 1'b0;
      div_start <= 1'b0;
    end else begin
      sqrt_start <= 1'b0;
      div_start <= 1'b0;
      if (cfg.valid) begin
        case (cfg.index)
          REG_TOL:    tol <= cfg.data;
          REG_SWITCH: sw <= cfg.data;
          default:    ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (vec.valid) begin
            wx <= 33'(vec.vec_x);
            wy <= 33'(vec.vec_y);
            wz <= 33'(vec.vec_z);
            last <= vec.last_in_batch;
            status <= ST_OK;
            phase <= PH_IN;
            pc <= PC_SQ;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= opa * opb;
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= acc_sum;
          state <= S_MUL;
          pc <= pc + 5'd1;
          if (op.last) begin
            case (pc)
              PC_SQ_END: begin
                sqrt_start <= 1'b1;
                state <= S_SQRT;
              end
              PC_CX_END: wx <= res;
              PC_CY_END: wy <= res;
              PC_CZ_END: begin
                wz <= res;
                phase <= PH_E2;
                pc <= PC_SQ;
              end
              PC_D0_END, PC_D1_END: begin
                if (sat31(scaled) > dot_peak) dot_peak <= sat31(scaled);
              end
              PC_D2_END: begin
                if (sat31(scaled) > dot_peak) dot_peak <= sat31(scaled);
                state <= S_OUT;
              end
              default: ;
            endcase
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            n <= root;
            di <= 2'd0;
            if (phase == PH_IN) begin
              if (sat31(ACC_W'(err)) > err_peak) err_peak <= sat31(ACC_W'(err));
              if (root == '0 || err > {1'b0, tol}) begin
                status <= ST_NOT_UNIT;
                state <= S_OUT;
              end else begin
                div_start <= 1'b1;
                state <= S_DIV;
              end
            end else if (root == '0) begin
              status <= ST_DEGEN;
              state <= S_OUT;
            end else begin
              div_start <= 1'b1;
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (di != 2'd2) begin
              if (di == 2'd0) begin
                wx <= qs;
              end else begin
                wy <= qs;
              end
              di <= di + 2'd1;
              div_start <= 1'b1;
            end else begin
              state <= S_MUL;
              case (phase)
                PH_IN: begin
                  mx <= wx;
                  my <= wy;
                  mz <= qs;
                  // reference y once |m_z| reaches the switch level
                  if (div_q >= {1'b0, sw}) begin
                    wx <= qs;
                    wy <= '0;
                    wz <= -wx;
                  end else begin
                    wx <= -wy;
                    wy <= wx;
                    wz <= '0;
                  end
                  phase <= PH_E1;
                  pc <= PC_SQ;
                end
                PH_E1: begin
                  ex <= wx;
                  ey <= wy;
                  ez <= qs;
                  pc <= PC_CROSS;
                end
                default: begin
                  wz <= qs;
                  pc <= PC_DOT;
                end
              endcase
            end
          end
        end
        S_OUT: begin
          if (frame.ready) begin
            if (last) begin
              err_peak <= '0;
              dot_peak <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    frame.valid = (state == S_OUT);
    frame.unit_x = (status == ST_NOT_UNIT) ? '0 : mx[31:0];
    frame.unit_y = (status == ST_NOT_UNIT) ? '0 : my[31:0];
    frame.unit_z = (status == ST_NOT_UNIT) ? '0 : mz[31:0];
    frame.first_x = (status == ST_OK) ? ex[31:0] : '0;
    frame.first_y = (status == ST_OK) ? ey[31:0] : '0;
    frame.first_z = (status == ST_OK) ? ez[31:0] : '0;
    frame.second_x = (status == ST_OK) ? wx[31:0] : '0;
    frame.second_y = (status == ST_OK) ? wy[31:0] : '0;
    frame.second_z = (status == ST_OK) ? wz[31:0] : '0;
    frame.status = status;
    frame.peak_norm_error = err_peak;
    frame.peak_basis_dot = dot_peak;
  end
endmodule

@@ rtl/core/tfb_sqrt.sv @@
// Bit-serial integer square root, one root bit per cycle.
module tfb_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  logic        busy;
  logic [4:0]  cnt;
  logic [63:0] rad;
  logic [33:0] rem;
  logic [35:0] t;
  logic [35:0] trial;
  logic        ge;

  always_comb begin
    t = {rem, rad[63:62]};
    trial = {2'b00, root, 2'b01};
    ge = t >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 5'd31;
        rad <= radicand;
        rem <= '0;
        root <= '0;
      end else if (busy) begin
        rad <= {rad[61:0], 2'b00};
        if (ge) begin
          rem <= 34'(t - trial);
          root <= {root[30:0], 1'b1};
        end else begin
          rem <= t[33:0];
          root <= {root[30:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ rtl/core/tfb_div.sv @@
// Bit-serial restoring divider: (dividend << FRACTION_BITS) / divisor, one quotient bit a cycle.
module tfb_div #(
  parameter int FRACTION_BITS = 30
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  localparam int CNT_W = $clog2(FRACTION_BITS + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [31:0]      r;
  logic             nb;
  logic [32:0]      t;
  logic             ge;

  // quotient never exceeds 2^FRACTION_BITS since dividend <= divisor
  always_comb begin
    t = {r, nb};
    ge = t >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(FRACTION_BITS);
        r <= {1'b0, dividend[31:1]};
        nb <= dividend[0];
        quotient <= '0;
      end else if (busy) begin
        r <= ge ? 32'(t - {1'b0, divisor}) : t[31:0];
        nb <= 1'b0;
        quotient <= {quotient[30:0], ge};
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ test/tfb_checker.sv @@
// Checker for the tangent frame builder: predicts each frame and compares it.
module tfb_checker (
  input  logic        clk,
  input  logic        rst,
  tfb_vec_if          vec,
  tfb_frame_if        frame,
  tfb_cfg_if          cfg,
  output int          fails,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tfb_pkg::*;

  localparam int FB = 30;
  localparam longint unsigned PEAK_TOP = 64'h7FFF_FFFF;

  typedef struct {
    logic signed [31:0] ux, uy, uz, fx, fy, fz, sx, sy, sz;
    logic [1:0]         status;
    logic [30:0]        peak_err, peak_dot;
  } frame_t;

  frame_t expected_frames[$];

  logic [30:0] tol_reg, switch_reg;
  logic [30:0] err_peak, dot_peak;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned length3(longint a, longint b, longint c);
    longint unsigned s;
    s = mag(a) * mag(a) + mag(b) * mag(b) + mag(c) * mag(c);
    return isqrt(s);
  endfunction

  // scale to unit length; returns 0 when the length is zero
  function automatic bit scale_unit(ref longint a, ref longint b, ref longint c);
    longint n;
    n = longint'(length3(a, b, c));
    if (n == 0) return 0;
    a = (a * (64'sd1 <<< FB)) / n;
    b = (b * (64'sd1 <<< FB)) / n;
    c = (c * (64'sd1 <<< FB)) / n;
    return 1;
  endfunction

  function automatic longint shrink(longint p);
    return p / (64'sd1 <<< FB);
  endfunction

  function automatic logic [30:0] peak_of(logic [30:0] pk, longint unsigned v);
    if (v > PEAK_TOP) v = PEAK_TOP;
    return (v[30:0] > pk) ? v[30:0] : pk;
  endfunction

  function automatic frame_t build_frame(longint x, longint y, longint z, bit last);
    frame_t f;
    longint ax, ay, az, bx, by, bz;
    longint unsigned n, err, one;
    logic [1:0] st;
    st = ST_OK;
    one = 64'd1 << FB;
    bx = 0; by = 0; bz = 0;
    ax = 0; ay = 0; az = 0;
    n = length3(x, y, z);
    err = (n >= one) ? n - one : one - n;
    err_peak = peak_of(err_peak, err);
    if (n == 0 || err > longint'(tol_reg)) begin
      st = ST_NOT_UNIT;
      x = 0; y = 0; z = 0;
    end else begin
      void'(scale_unit(x, y, z));
      if (mag(z) >= longint'(switch_reg)) begin
        ax = z; ay = 0; az = -x;
      end else begin
        ax = -y; ay = x; az = 0;
      end
      if (!scale_unit(ax, ay, az)) begin
        st = ST_DEGEN;
      end else begin
        bx = shrink(y * az - z * ay);
        by = shrink(z * ax - x * az);
        bz = shrink(x * ay - y * ax);
        if (!scale_unit(bx, by, bz)) st = ST_DEGEN;
      end
      if (st == ST_DEGEN) begin
        ax = 0; ay = 0; az = 0; bx = 0; by = 0; bz = 0;
      end else begin
        dot_peak = peak_of(dot_peak, mag(shrink(x * ax + y * ay + z * az)));
        dot_peak = peak_of(dot_peak, mag(shrink(x * bx + y * by + z * bz)));
        dot_peak = peak_of(dot_peak, mag(shrink(ax * bx + ay * by + az * bz)));
      end
    end
    f.ux = x[31:0]; f.uy = y[31:0]; f.uz = z[31:0];
    f.fx = ax[31:0]; f.fy = ay[31:0]; f.fz = az[31:0];
    f.sx = bx[31:0]; f.sy = by[31:0]; f.sz = bz[31:0];
    f.status = st;
    f.peak_err = err_peak;
    f.peak_dot = dot_peak;
    if (last) begin
      err_peak = '0;
      dot_peak = '0;
    end
    return f;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
    fails++;
  endtask

  task automatic compare(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(field, got, want);
  endtask

  assign pending = expected_frames.size();

  always @(posedge clk) begin
    frame_t w;
    if (rst) begin
      tol_reg <= TOL_RESET;
      switch_reg <= SWITCH_RESET;
      err_peak = '0;
      dot_peak = '0;
      fails = 0;
      expected_frames.delete();
    end else begin
      if (frame.valid && frame.ready) begin
        if (expected_frames.size() == 0) begin
          $display("unexpected frame transaction at %0t", $realtime);
          fails++;
        end else begin
          w = expected_frames.pop_front();
          compare("unit_x", frame.unit_x, w.ux);
          compare("unit_y", frame.unit_y, w.uy);
          compare("unit_z", frame.unit_z, w.uz);
          compare("first_x", frame.first_x, w.fx);
          compare("first_y", frame.first_y, w.fy);
          compare("first_z", frame.first_z, w.fz);
          compare("second_x", frame.second_x, w.sx);
          compare("second_y", frame.second_y, w.sy);
          compare("second_z", frame.second_z, w.sz);
          compare("status", 32'(frame.status), 32'(w.status));
          compare("peak_norm_error", 32'(frame.peak_norm_error), 32'(w.peak_err));
          compare("peak_basis_dot", 32'(frame.peak_basis_dot), 32'(w.peak_dot));
        end
      end
      if (vec.valid && vec.ready)
        expected_frames.push_back(build_frame(longint'(vec.vec_x), longint'(vec.vec_y),
                                              longint'(vec.vec_z), vec.last_in_batch));
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_TOL) tol_reg <= cfg.data;
        else if (cfg.index == REG_SWITCH) switch_reg <= cfg.data;
      end
    end
  end
endmodule

@@ test/testbench.sv @@
// Top of the tangent frame builder testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tfb_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE = 600;
  localparam logic signed [31:0] ONE = 32'sd1 << 30;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic [30:0] U_MAX = 31'h7FFF_FFFF;

  logic clk, rst;
  bit   steady;
  int   fails, pending;
  int   cycles = 0;

  tfb_vec_if   vec();
  tfb_frame_if frame();
  tfb_cfg_if   cfg();

  tangent_frame_builder u_dut (.clk(clk), .rst(rst), .vec(vec), .frame(frame), .cfg(cfg));

  tfb_checker u_checker (.clk(clk), .rst(rst), .vec(vec), .frame(frame), .cfg(cfg),
                         .fails(fails), .pending(pending));

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk) frame.ready <= steady || ($urandom_range(99) >= 14);

  task automatic send_vec(logic signed [31:0] x, y, z, bit last);
    if (!steady && $urandom_range(99) < 14) begin
      vec.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 50);
    end
    vec.valid <= 1'b1;
    vec.vec_x <= x;
    vec.vec_y <= y;
    vec.vec_z <= z;
    vec.last_in_batch <= last;
    do @(posedge clk); while (!vec.ready);
    @(negedge clk);
  endtask

  // lets the block finish before a register write or a pause
  task automatic drain();
    vec.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [30:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
  endtask

  task automatic set_regs(logic [30:0] tol, logic [30:0] sw);
    drain();
    write_reg(REG_TOL, tol);
    write_reg(REG_SWITCH, sw);
    cfg.valid <= 1'b0;
  endtask

  // near-unit vector with random direction; z_bias leans it toward the z axis
  task automatic send_near_unit(bit z_bias, int jitter);
    real ax, ay, az, len, k;
    logic signed [31:0] x, y, z;
    do begin
      ax = $urandom_range(0, 2000000) / 1.0e6 - 1.0;
      ay = $urandom_range(0, 2000000) / 1.0e6 - 1.0;
      az = $urandom_range(0, 2000000) / 1.0e6 - 1.0;
      if (z_bias) begin
        ax = ax * 0.3;
        ay = ay * 0.3;
      end
      len = $sqrt(ax * ax + ay * ay + az * az);
    end while (len < 1.0e-3);
    k = 1073741824.0 / len;
    x = $rtoi(ax * k) + $urandom_range(0, 2 * jitter) - jitter;
    y = $rtoi(ay * k) + $urandom_range(0, 2 * jitter) - jitter;
    z = $rtoi(az * k) + $urandom_range(0, 2 * jitter) - jitter;
    send_vec(x, y, z, $urandom_range(7) == 0);
  endtask

  task automatic directed_set();
    send_vec(0, 0, 0, 0);
    send_vec(ONE, 0, 0, 0);
    send_vec(0, ONE, 0, 0);
    send_vec(0, 0, ONE, 0);
    send_vec(0, 0, -ONE, 1);
    send_vec(S_MIN, S_MIN, S_MIN, 0);
    send_vec(S_MAX, S_MAX, S_MAX, 0);
    send_vec(ONE + 5, 0, 3, 1);
  endtask

  initial begin
    int phase, n, kind;
    rst = 1'b1;
    steady = 1'b0;
    vec.valid = 1'b0;
    vec.vec_x = '0;
    vec.vec_y = '0;
    vec.vec_z = '0;
    vec.last_in_batch = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = REG_TOL;
    cfg.data = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    directed_set();
    // widest tolerance, switch never reached: z axis gives a degenerate basis
    set_regs(U_MAX, U_MAX);
    directed_set();
    // zero tolerance, switch zero: reference is always y
    set_regs('0, '0);
    directed_set();
    set_regs(31'(ONE), 31'(ONE));
    directed_set();

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_regs(TOL_RESET, SWITCH_RESET);
        1: set_regs(31'($urandom_range(0, 64)), 31'($urandom_range(0, 1 << 30)));
        2: set_regs(U_MAX, 31'($urandom));
        3: set_regs(31'($urandom_range(8, 40)), 31'($urandom_range(900000000, 1 << 30)));
        4: set_regs('0, SWITCH_RESET);
        default: set_regs(31'($urandom), 31'($urandom));
      endcase
      for (n = 0; n < 80; n++) begin
        steady = (phase == 2 && n >= 20 && n < 70);
        kind = $urandom_range(99);
        if (kind < 15)
          send_vec($urandom, $urandom, $urandom, 1'($urandom_range(1)));
        else if (kind < 40)
          send_near_unit(1'b1, $urandom_range(0, 12));
        else
          send_near_unit(1'b0, $urandom_range(0, 12));
        if (phase == 3 && n == 40) drain();
      end
    end
    steady = 1'b0;

    drain();
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

@@ tangent_frame_builder.f @@
rtl/core/tfb_pkg.sv
rtl/core/tfb_vec_if.sv
rtl/core/tfb_frame_if.sv
rtl/core/tfb_cfg_if.sv
rtl/core/tfb_sqrt.sv
rtl/core/tfb_div.sv
rtl/core/tangent_frame_builder.sv
test/tfb_checker.sv
test/testbench.sv
